FILE: hw/rtl/array_steering_weights_assert.svh
// Assertion macros used by the checker of the steering weight block.
`ifndef ARRAY_STEERING_WEIGHTS_ASSERT_SVH
`define ARRAY_STEERING_WEIGHTS_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASW_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ASW_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/asw_pkg.sv
package asw_pkg;

  localparam int NUM_ELEM  = 4;
  localparam int NUM_TERMS = 9;
  localparam int MOD_STEPS = 14;
  localparam int CORE_LAT  = NUM_TERMS + 2;
  localparam int PIPE_DEPTH = 2 * CORE_LAT + MOD_STEPS + 4;

  localparam logic [31:0] HPI_Q28    = 32'h1921FB54;
  localparam logic [31:0] QPI_Q28    = 32'h0C90FDAA;
  localparam logic [50:0] TWO_PI_Q48 = 51'h6487ED5110B46;
  localparam logic [16:0] FACTOR_Q32 = 17'd90016;
  localparam logic signed [30:0] ONE_Q28 = 31'sh10000000;

  typedef enum logic [2:0] {
    REG_CARRIER    = 3'd0,
    REG_POS_FIRST  = 3'd1,
    REG_POS_SECOND = 3'd2,
    REG_POS_THIRD  = 3'd3,
    REG_POS_FOURTH = 3'd4
  } reg_idx_t;

  // One Taylor term: divide by n! through a reciprocal multiply.
  typedef struct packed {
    logic [28:0] recip;
    logic [5:0]  shift;
    logic        to_sin;
    logic        sub;
  } coef_t;

  typedef struct packed {
    logic [27:0]        a;
    logic [27:0]        pw;
    logic signed [30:0] c;
    logic signed [30:0] s;
    logic               neg;
    logic [1:0]         quad;
  } core_t;

  typedef struct packed {
    logic [64:0] m;
    logic        neg;
  } mod_t;

  // The reciprocal is ceil(2^shift / n!) with shift = 28 + ceil(log2 n!),
  // which gives an exact floor for any 28-bit power.
  function automatic coef_t coef_of(input int idx);
    coef_t r;
    r = '{recip: 29'd0, shift: 6'd0, to_sin: 1'b1, sub: 1'b0};
    case (idx)
      1: r = '{recip: 29'd268435456, shift: 6'd29, to_sin: 1'b0, sub: 1'b1};
      2: r = '{recip: 29'd357913942, shift: 6'd31, to_sin: 1'b1, sub: 1'b1};
      3: r = '{recip: 29'd357913942, shift: 6'd33, to_sin: 1'b0, sub: 1'b0};
      4: r = '{recip: 29'd286331154, shift: 6'd35, to_sin: 1'b1, sub: 1'b0};
      5: r = '{recip: 29'd381774871, shift: 6'd38, to_sin: 1'b0, sub: 1'b1};
      6: r = '{recip: 29'd436314139, shift: 6'd41, to_sin: 1'b1, sub: 1'b1};
      7: r = '{recip: 29'd436314139, shift: 6'd44, to_sin: 1'b0, sub: 1'b0};
      8: r = '{recip: 29'd387834790, shift: 6'd47, to_sin: 1'b1, sub: 1'b0};
      default: r = '{recip: 29'd0, shift: 6'd0, to_sin: 1'b1, sub: 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic [64:0] mod_div(input int step);
    return {14'd0, TWO_PI_Q48} << step;
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [30:0] v);
    logic signed [31:0] t;
    logic signed [18:0] q;
    logic signed [15:0] r;
    t = 32'(v) + 32'sd4096;
    q = 19'(t >>> 13);
    if (q > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (q < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/asw_term_cell.sv
module asw_term_cell
  import asw_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  coef_t coef,
  input  core_t din,
  output core_t dout
);

  logic [56:0]        term_prod;
  logic [55:0]        pw_prod;
  logic signed [30:0] term;
  core_t              nxt;

  always_comb begin
    term_prod = 57'(din.pw) * 57'(coef.recip);
    term = $signed({2'b00, 29'(term_prod >> coef.shift)});
    pw_prod = 56'(din.pw) * 56'(din.a);
    nxt = din;
    nxt.pw = pw_prod[55:28];
    if (coef.to_sin) begin
      nxt.s = coef.sub ? din.s - term : din.s + term;
    end else begin
      nxt.c = coef.sub ? din.c - term : din.c + term;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: hw/rtl/asw_mod_cell.sv
module asw_mod_cell
  import asw_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [64:0] div,
  input  mod_t        din,
  output mod_t        dout
);

  always_ff @(posedge clk) begin
    if (en) begin
      dout.neg <= din.neg;
      dout.m   <= (din.m >= div) ? din.m - div : din.m;
    end
  end

endmodule

FILE: hw/rtl/asw_sincos.sv
module asw_sincos
  import asw_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [30:0]        x,
  output logic signed [30:0] c,
  output logic signed [30:0] s
);

  logic [31:0]        xq;
  logic [2:0]         k;
  logic [31:0]        kh;
  logic signed [32:0] r;
  logic [32:0]        r_abs;
  core_t              init;
  core_t              chain [NUM_TERMS+1];
  logic signed [30:0] sp;

  // Quadrant from threshold compares; the argument stays below four times pi/2.
  always_comb begin
    xq = {1'b0, x} + QPI_Q28;
    k = 3'd0;
    for (int n = 1; n <= 4; n++) begin
      if (xq >= 32'(n) * HPI_Q28) begin
        k = 3'(n);
      end
    end
    kh = 32'(k) * HPI_Q28;
    r = $signed({2'b00, x}) - $signed({1'b0, kh});
    r_abs = r[32] ? 33'(-r) : 33'(r);
    init.a = r_abs[27:0];
    init.pw = r_abs[27:0];
    init.c = ONE_Q28;
    init.s = $signed({3'b000, r_abs[27:0]});
    init.neg = r[32];
    init.quad = k[1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= init;
    end
  end

  for (genvar i = 0; i < NUM_TERMS; i++) begin : g_cell
    asw_term_cell u_cell (
      .clk  (clk),
      .en   (en),
      .coef (coef_of(i)),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  assign sp = chain[NUM_TERMS].neg ? -chain[NUM_TERMS].s : chain[NUM_TERMS].s;

  always_ff @(posedge clk) begin
    if (en) begin
      case (chain[NUM_TERMS].quad)
        2'd0: begin c <= chain[NUM_TERMS].c;  s <= sp; end
        2'd1: begin c <= -sp;                 s <= chain[NUM_TERMS].c; end
        2'd2: begin c <= -chain[NUM_TERMS].c; s <= -sp; end
        default: begin c <= sp;               s <= -chain[NUM_TERMS].c; end
      endcase
    end
  end

endmodule

FILE: hw/rtl/array_steering_weights.sv
// Steering weights for a four-element linear array.
// Input channel: angle (signed Q3.17 radians) with angle_valid / angle_stall.
// Output channel: cosine and sine weights of the four elements in Q1.15 with
// weight_valid / weight_stall. A request moves when valid is high and stall low.
// Configuration: cfg_write with cfg_index selects carrier (0) or the element
// positions (1 to 4); cfg_data is taken at the clock edge. Write only while idle.
// Throughput is one request per cycle unless the output stalls: cos(angle) runs
// through a chain of nine Taylor term cells, the phase reduction through fourteen
// compare and subtract cells, and the element sines and cosines through four more
// term cell chains.
// When the receiver stalls a valid result, the whole pipeline holds and
// angle_stall rises in the same cycle; no request is dropped.
// Reset clears all pipeline valid bits and the configuration registers.
module array_steering_weights
  import asw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               angle_valid,
  output logic               angle_stall,
  input  logic signed [19:0] angle,
  output logic               weight_valid,
  input  logic               weight_stall,
  output logic signed [15:0] first_real,
  output logic signed [15:0] first_imag,
  output logic signed [15:0] second_real,
  output logic signed [15:0] second_imag,
  output logic signed [15:0] third_real,
  output logic signed [15:0] third_imag,
  output logic signed [15:0] fourth_real,
  output logic signed [15:0] fourth_imag,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [30:0]        carrier_mhz;
  logic signed [31:0] position [NUM_ELEM];
  logic [31:0]        phase_scale;
  logic [47:0]        scale_prod;
  logic               en;
  logic [PIPE_DEPTH-1:0] vld;
  logic [19:0]        angle_abs;
  logic [30:0]        mag;
  logic signed [30:0] cphi;
  logic [29:0]        cabs;
  logic [32:0]        a_prod [NUM_ELEM];
  mod_t               mods [NUM_ELEM][MOD_STEPS+1];
  logic [30:0]        x2 [NUM_ELEM];
  logic signed [30:0] wc [NUM_ELEM];
  logic signed [30:0] ws [NUM_ELEM];

  assign en = !(weight_valid && weight_stall);
  assign angle_stall = weight_valid && weight_stall;
  assign weight_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_mhz <= '0;
      for (int i = 0; i < NUM_ELEM; i++) begin
        position[i] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CARRIER:    carrier_mhz <= cfg_data[30:0];
        REG_POS_FIRST:  position[0] <= cfg_data;
        REG_POS_SECOND: position[1] <= cfg_data;
        REG_POS_THIRD:  position[2] <= cfg_data;
        REG_POS_FOURTH: position[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unenforced user rule: configuration changes only while idle; product lags.
  assign scale_prod = 48'(FACTOR_Q32) * 48'(carrier_mhz);
  always_ff @(posedge clk) begin
    phase_scale <= scale_prod[47:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], angle_valid};
    end
  end

  assign angle_abs = angle[19] ? 20'(-angle) : 20'(angle);
  assign mag = {angle_abs, 11'd0};

  asw_sincos u_phi (
    .clk (clk),
    .en  (en),
    .x   (mag),
    .c   (cphi),
    .s   ()
  );

  assign cabs = cphi[30] ? 30'(-cphi) : 30'(cphi);

  for (genvar e = 0; e < NUM_ELEM; e++) begin : g_elem
    logic [31:0] pabs;
    logic        neg_a;
    logic [61:0] ap_full;
    logic [64:0] mp_full;
    logic [50:0] wrapped;

    assign pabs = position[e][31] ? 32'(-position[e]) : 32'(position[e]);
    assign ap_full = 62'(cabs) * 62'(pabs);
    assign mp_full = 65'(phase_scale) * 65'(a_prod[e]);

    always_ff @(posedge clk) begin
      if (en) begin
        a_prod[e] <= ap_full[60:28];
        neg_a <= cphi[30] != position[e][31];
        mods[e][0].m <= mp_full;
        mods[e][0].neg <= neg_a;
      end
    end

    for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
      asw_mod_cell u_mod (
        .clk  (clk),
        .en   (en),
        .div  (mod_div(MOD_STEPS - 1 - j)),
        .din  (mods[e][j]),
        .dout (mods[e][j+1])
      );
    end

    // A negative phase maps to its positive residue below two pi.
    always_comb begin
      wrapped = mods[e][MOD_STEPS].m[50:0];
      if (mods[e][MOD_STEPS].neg && (mods[e][MOD_STEPS].m != '0)) begin
        wrapped = TWO_PI_Q48 - mods[e][MOD_STEPS].m[50:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x2[e] <= {wrapped[50:34], 14'd0};
      end
    end

    asw_sincos u_weight (
      .clk (clk),
      .en  (en),
      .x   (x2[e]),
      .c   (wc[e]),
      .s   (ws[e])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      first_real  <= to_q15(wc[0]);
      first_imag  <= to_q15(ws[0]);
      second_real <= to_q15(wc[1]);
      second_imag <= to_q15(ws[1]);
      third_real  <= to_q15(wc[2]);
      third_imag  <= to_q15(ws[2]);
      fourth_real <= to_q15(wc[3]);
      fourth_imag <= to_q15(ws[3]);
    end
  end

endmodule

FILE: hw/rtl/asw_checker.sv
`include "array_steering_weights_assert.svh"

module asw_checker (
  input logic               clk,
  input logic               rst,
  input logic               angle_valid,
  input logic               angle_stall,
  input logic               weight_valid,
  input logic               weight_stall,
  input logic signed [15:0] first_real
);

  // The input side holds exactly when a finished result is held back.
  `ASW_IMPLY(a_stall_tracks_output, 1'b1, angle_stall == (weight_valid && weight_stall), "angle_stall does not follow the output stall")

  // No result is presented in the first cycle after reset.
  `ASW_IMPLY(a_idle_after_reset, $past(rst), !weight_valid, "result valid right after reset")

  `ASW_NEXT(a_valid_held, weight_valid && weight_stall, weight_valid, "stalled result dropped")

  `ASW_NEXT(a_payload_held, weight_valid && weight_stall, $stable(first_real), "stalled result changed")

endmodule

bind array_steering_weights asw_checker u_asw_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import asw_pkg::*;

  typedef logic [63:0] u64;
  typedef logic [7:0][15:0] weight_set_t;

  localparam u64 HALF_PI = 64'h1921FB54;
  localparam u64 QUARTER_PI = 64'h0C90FDAA;
  localparam u64 FULL_TURN = 64'h6487ED5110B46;
  localparam u64 PHASE_FACTOR = 64'd90016;
  localparam longint UNITY = longint'(1) <<< 28;
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int ANGLE_PI = 411775;
  localparam int LATENCY = 40;

  class weight_scoreboard;
    u64 carrier;
    longint pos[4];
    weight_set_t expected_weights[$];
    int errors;

    function new();
      carrier = 0;
      foreach (pos[i]) pos[i] = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      if (idx == REG_CARRIER) carrier = {33'd0, data[30:0]};
      else if (idx >= REG_POS_FIRST && idx <= REG_POS_FOURTH)
        pos[idx - 1] = longint'($signed(data));
    endfunction

    static function void sin_cos(u64 x, output longint c, output longint s);
      u64 k, a, a2, a3, a4, a5, a6, a7, a8, a9;
      longint r, cp, sp;
      k = (x + QUARTER_PI) / HALF_PI;
      r = longint'(x) - longint'(k * HALF_PI);
      a = (r < 0) ? u64'(-r) : u64'(r);
      a2 = (a * a) >> 28;
      a3 = (a2 * a) >> 28;
      a4 = (a3 * a) >> 28;
      a5 = (a4 * a) >> 28;
      a6 = (a5 * a) >> 28;
      a7 = (a6 * a) >> 28;
      a8 = (a7 * a) >> 28;
      a9 = (a8 * a) >> 28;
      cp = UNITY - longint'(a2 / 2) + longint'(a4 / 24) - longint'(a6 / 720)
           + longint'(a8 / 40320);
      sp = longint'(a) - longint'(a3 / 6) + longint'(a5 / 120) - longint'(a7 / 5040)
           + longint'(a9 / 362880);
      if (r < 0) sp = -sp;
      case (k[1:0])
        2'd0: begin c = cp; s = sp; end
        2'd1: begin c = -sp; s = cp; end
        2'd2: begin c = -cp; s = -sp; end
        default: begin c = sp; s = -cp; end
      endcase
    endfunction

    static function logic [15:0] round_q15(longint v);
      u64 t;
      longint q;
      t = u64'(v + (longint'(1) <<< 30) + 4096) >> 13;
      q = longint'(t) - (longint'(1) <<< 17);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_angle(logic signed [19:0] ang);
      longint av, cphi, dummy, c, s;
      u64 p, cabs, pabs, a, m;
      weight_set_t w;
      bit neg;
      av = ang;
      sin_cos(u64'(av < 0 ? -av : av) * 2048, cphi, dummy);
      p = (PHASE_FACTOR * carrier) >> 16;
      cabs = u64'(cphi < 0 ? -cphi : cphi);
      for (int e = 0; e < 4; e++) begin
        pabs = u64'(pos[e] < 0 ? -pos[e] : pos[e]);
        neg = (cphi < 0) != (pos[e] < 0);
        a = (cabs * pabs) >> 28;
        m = (p * a) % FULL_TURN;
        if (neg && m != 0) m = FULL_TURN - m;
        sin_cos((m >> 34) << 14, c, s);
        w[2 * e] = round_q15(c);
        w[2 * e + 1] = round_q15(s);
      end
      expected_weights.push_back(w);
    endfunction

    function void check_weights(weight_set_t got);
      weight_set_t want;
      if (expected_weights.size() == 0) begin
        $display("%0t: unexpected weight request %h", $realtime, got);
        errors++;
        return;
      end
      want = expected_weights.pop_front();
      for (int f = 0; f < 8; f++)
        if (want[f] !== got[f]) begin
          $display("%0t: field %0d expected %0d actual %0d", $realtime, f,
                   $signed(want[f]), $signed(got[f]));
          errors++;
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic angle_valid = 0;
  logic angle_stall;
  logic signed [19:0] angle = 0;
  logic weight_valid;
  logic weight_stall = 0;
  logic signed [15:0] first_real, first_imag, second_real, second_imag;
  logic signed [15:0] third_real, third_imag, fourth_real, fourth_imag;
  logic cfg_write = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  weight_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  array_steering_weights dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && angle_valid && !angle_stall) sb.note_angle(angle);
    if (!rst && weight_valid && !weight_stall)
      sb.check_weights({fourth_imag, fourth_real, third_imag, third_real,
                        second_imag, second_real, first_imag, first_real});
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      weight_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      weight_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_write <= 0;
  endtask

  task automatic load_regs(logic [31:0] fc, logic [31:0] p0, logic [31:0] p1,
                           logic [31:0] p2, logic [31:0] p3);
    write_reg(REG_CARRIER, fc);
    write_reg(REG_POS_FIRST, p0);
    write_reg(REG_POS_SECOND, p1);
    write_reg(REG_POS_THIRD, p2);
    write_reg(REG_POS_FOURTH, p3);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_angle(logic signed [19:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      angle_valid <= 0;
      @(negedge clk);
    end
    angle_valid <= 1;
    angle <= v;
    do @(posedge clk); while (angle_stall);
    @(negedge clk);
  endtask

  // Called at a falling edge, so the last request is withdrawn before the next edge.
  task automatic drain();
    angle_valid <= 0;
    @(negedge clk);
    while (sb.expected_weights.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic signed [19:0] random_angle();
    if ($urandom_range(0, 3) == 0) return 20'($urandom);
    return 20'($signed($urandom_range(0, 2 * ANGLE_PI)) - ANGLE_PI);
  endfunction

  task automatic directed_angles();
    logic signed [19:0] pts[10] = '{20'sd0, 20'sd524287, -20'sd524288, 20'sd411775,
                                   -20'sd411775, 20'sd205887, 20'sd1, -20'sd1,
                                   20'sd102944, -20'sd274517};
    foreach (pts[i]) send_angle(pts[i]);
  endtask

  task automatic random_regs();
    load_regs($urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic random_burst(int n);
    repeat (n) send_angle(random_angle());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    repeat (3) @(negedge clk);

    // Zero registers after reset give unity weights.
    directed_angles();
    drain();
    // Spare register indexes must not disturb the live settings.
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h1234_5678);
    send_angle(20'sd0);
    drain();

    load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    directed_angles();
    drain();
    load_regs(32'd2400 << 16, 32'd0, 32'd62 << 16, 32'hFFC2_0000, 32'd186 << 16);
    directed_angles();
    drain();

    send_idle_pct = 12;
    recv_idle_pct = 49;
    random_regs();
    random_burst(350);
    drain();
    load_regs(32'd5800 << 16, 32'd0, 32'd13 << 16, 32'd26 << 16, 32'd39 << 16);
    random_burst(300);
    drain();

    send_idle_pct = 49;
    recv_idle_pct = 12;
    random_regs();
    random_burst(350);
    drain();
    write_reg(REG_CARRIER, 32'h7FFF_FFFF);
    random_burst(300);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_regs();
    // The receiver holds off while angles keep coming, filling the pipeline.
    hold_cycles = 150;
    random_burst(350);
    drain();
    random_regs();
    random_burst(350);
    drain();

    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
